// File: sv/hgni_pkg.sv
// hgni_pkg: shared types, widths, status codes, configuration register indices
// and the divider step for the halo ghost node lookup. No dependencies.
`default_nettype none
package hgni_pkg;

  localparam int NW = 24;  // node number / divider width
  localparam int CW = 26;  // signed patch-relative coordinate width
  localparam int GW = 36;  // signed ghost index arithmetic width

  localparam logic [1:0] ST_OWNED   = 2'd0;
  localparam logic [1:0] ST_GHOST   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [2:0] REG_ORIGIN_COL      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_ROW      = 3'd1;
  localparam logic [2:0] REG_ORIGIN_RANK     = 3'd2;
  localparam logic [2:0] REG_COLS_IN_PATCH   = 3'd3;
  localparam logic [2:0] REG_ROWS_IN_PATCH   = 3'd4;
  localparam logic [2:0] REG_RANKS_IN_PATCH  = 3'd5;
  localparam logic [2:0] REG_NODES_PER_ROW   = 3'd6;
  localparam logic [2:0] REG_NODES_PER_SLICE = 3'd7;

  // One stage of the restoring divider pipeline.
  typedef struct packed {
    logic          v;
    logic          bad;
    logic [NW-1:0] rem;
    logic [NW-1:0] q;    // dividend bits shift out, quotient bits shift in
    logic [NW-1:0] aux;
  } dv_t;

  // One quotient bit: shift in the next dividend bit, subtract when it fits.
  function automatic dv_t div_step(dv_t s, logic [NW-1:0] d);
    logic [NW:0] t;
    dv_t         o;
    t = {s.rem, s.q[NW-1]};
    o = s;
    if (t >= {1'b0, d}) begin
      o.rem = NW'(t - {1'b0, d});
      o.q   = {s.q[NW-2:0], 1'b1};
    end else begin
      o.rem = t[NW-1:0];
      o.q   = {s.q[NW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: sv/halo_ghost_node_index.sv
// halo_ghost_node_index: pipelined ghost-list lookup for one global grid node.
// Depends on hgni_pkg (types, status codes, divider step).
//
// Each beat on the input channel carries a one-based global node number and
// produces exactly one result beat: status (owned, ghost, outside halo, or
// ghost index out of range) and the dense ghost-list index. The block takes
// one beat per clock while the output is not stalled, and passes it through
// one capture stage, 24 stages of a bit-per-stage restoring divider by
// nodes_per_slice, one load stage and 24 stages of a second divider by
// nodes_per_row, then coordinate, multiply, sum and output stages. The
// whole pipe advances together; it stalls only when the output register holds
// a beat that is not taken, and then nothing is lost or repeated. Write the
// configuration registers only while the pipe is empty; values derived from
// them settle through two register layers after the last write.
`default_nettype none
module halo_ghost_node_index #(
  parameter int HALO_WIDTH = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [23:0]             cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [hgni_pkg::NW-1:0] in_node_number,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic [hgni_pkg::NW-1:0]      out_ghost_index
);
  import hgni_pkg::*;

  localparam int H     = HALO_WIDTH;
  localparam int INNER = 2 * H + 1;
  localparam int DS    = NW;  // divider stages per division

  // ---------------- configuration registers ----------------
  logic [11:0] origin_col_r, origin_row_r, origin_rank_r;
  logic [11:0] cols_r, rows_r, ranks_r;
  logic [12:0] npr_r;
  logic [23:0] nps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_col_r <= '0;
      origin_row_r <= '0;
      origin_rank_r <= '0;
      cols_r <= 12'd1;
      rows_r <= 12'd1;
      ranks_r <= '0;
      npr_r <= 13'd1;
      nps_r <= 24'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_COL:      origin_col_r <= cfg_wdata[11:0];
        REG_ORIGIN_ROW:      origin_row_r <= cfg_wdata[11:0];
        REG_ORIGIN_RANK:     origin_rank_r <= cfg_wdata[11:0];
        REG_COLS_IN_PATCH:   cols_r <= cfg_wdata[11:0];
        REG_ROWS_IN_PATCH:   rows_r <= cfg_wdata[11:0];
        REG_RANKS_IN_PATCH:  ranks_r <= cfg_wdata[11:0];
        REG_NODES_PER_ROW:   npr_r <= cfg_wdata[12:0];
        REG_NODES_PER_SLICE: nps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic is3d;
  assign is3d = (ranks_r != '0);

  // ---------------- derived layout constants (two register layers) -------
  logic [GW-1:0] full_r, base_part_r, base_top_r, full_rank_r, inner_rank_r;
  logic [GW-1:0] base_int_r, base_apex_r, total2d_r, total3d_r;
  logic [12:0]   full_w;
  logic [13:0]   yfull_w;
  assign full_w  = 13'(cols_r) + 13'(INNER);
  assign yfull_w = 14'(full_w) + 14'(rows_r);

  always_ff @(posedge clk) begin
    full_r       <= GW'(full_w);
    base_part_r  <= GW'(full_w) * GW'(H);
    base_top_r   <= GW'(full_w) * GW'(H) + GW'(rows_r) * GW'(INNER);
    full_rank_r  <= GW'(26'(full_w) * 26'(13'(rows_r) + 13'(INNER)));
    inner_rank_r <= GW'(yfull_w) * GW'(INNER);
    total2d_r    <= GW'(yfull_w) * GW'(INNER);
    base_int_r   <= full_rank_r * GW'(H);
    base_apex_r  <= full_rank_r * GW'(H) + GW'(30'(ranks_r) * 30'(inner_rank_r[17:0]));
    total3d_r    <= full_rank_r * GW'(INNER) + GW'(30'(ranks_r) * 30'(inner_rank_r[17:0]));
  end

  // ---------------- pipeline enable ----------------
  logic out_valid_r;
  logic en;
  // Advance everything unless the output beat is held.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------- divider by nodes_per_slice ----------------
  // Stage 0 captures n = num - 1; aux keeps n for the 2D case.
  dv_t a_r [0:DS];
  dv_t b_r [0:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DS; k++) begin
        a_r[k].v <= 1'b0;
        b_r[k].v <= 1'b0;
      end
    end else if (en) begin
      a_r[0].v   <= in_valid;
      a_r[0].bad <= (in_node_number == '0) || (npr_r == '0) ||
                    (is3d && nps_r == '0);
      a_r[0].rem <= '0;
      a_r[0].q   <= in_node_number - NW'(1);
      a_r[0].aux <= in_node_number - NW'(1);
      for (int k = 1; k <= DS; k++) begin
        a_r[k] <= div_step(a_r[k-1], nps_r);
      end
      // Load the row divider: remainder in 3D, the node itself in 2D.
      b_r[0].v   <= a_r[DS].v;
      b_r[0].bad <= a_r[DS].bad;
      b_r[0].rem <= '0;
      b_r[0].q   <= is3d ? a_r[DS].rem : a_r[DS].aux;
      b_r[0].aux <= a_r[DS].q;
      for (int k = 1; k <= DS; k++) begin
        b_r[k] <= div_step(b_r[k-1], NW'(npr_r));
      end
    end
  end

  // ---------------- stage P1: patch-relative coordinates ----------------
  logic                 p1_v_r, p1_bad_r;
  logic signed [CW-1:0] p1_col_r, p1_row_r, p1_rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= b_r[DS].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_bad_r  <= b_r[DS].bad;
      p1_col_r  <= $signed(CW'(b_r[DS].rem)) - $signed(CW'(origin_col_r));
      p1_row_r  <= $signed(CW'(b_r[DS].q)) - $signed(CW'(origin_row_r));
      p1_rank_r <= is3d ? $signed(CW'(b_r[DS].aux)) - $signed(CW'(origin_rank_r))
                        : '0;
    end
  end

  // ---------------- stage P2: classify and form products ----------------
  logic signed [CW-1:0] xn_s, yn_s, zn_s, h_s;
  assign xn_s = $signed(CW'(cols_r));
  assign yn_s = $signed(CW'(rows_r));
  assign zn_s = $signed(CW'(ranks_r));
  assign h_s  = $signed(CW'(H));

  logic          owned_w, outside_w;
  logic [2:0]    rowt_w, rank_sel_w;
  logic signed [CW-1:0] rowh_full_w, rowt_full_w, rank_t_w;

  always_comb begin
    owned_w = (p1_row_r >= 0) && (p1_row_r < yn_s) && (p1_col_r >= 0) &&
              (p1_col_r < xn_s) &&
              (!is3d || ((p1_rank_r >= 0) && (p1_rank_r < zn_s)));
    outside_w = (p1_row_r < -h_s) || (p1_row_r > yn_s + h_s) ||
                (p1_col_r < -h_s) || (p1_col_r > xn_s + h_s) ||
                (is3d && ((p1_rank_r < -h_s) || (p1_rank_r > zn_s + h_s)));
    rowh_full_w = p1_row_r + h_s;
    rowt_full_w = p1_row_r - yn_s;
    rank_t_w    = (p1_rank_r < 0) ? p1_rank_r + h_s : p1_rank_r - zn_s;
    // Only the halo band matters here, where these offsets lie in 0..H.
    rowt_w     = rowt_full_w[2:0];
    rank_sel_w = rank_t_w[2:0];
  end

  logic                 p2_v_r, p2_bad_r, p2_owned_r, p2_outside_r;
  logic signed [CW-1:0] p2_col_r, p2_row_r, p2_rank_r;
  logic [25:0]          p2_pa_r;
  logic [15:0]          p2_pb_r, p2_pc_r;
  logic [27:0]          p2_pr_r;
  logic [29:0]          p2_pi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_bad_r     <= p1_bad_r;
      p2_owned_r   <= owned_w;
      p2_outside_r <= outside_w;
      p2_col_r     <= p1_col_r;
      p2_row_r     <= p1_row_r;
      p2_rank_r    <= p1_rank_r;
      // Row offset from the halo bottom spans the whole patch height plus halo.
      p2_pa_r      <= 26'(rowh_full_w[12:0]) * 26'(full_r[12:0]);
      p2_pb_r      <= 16'(rowt_w) * 16'(full_r[12:0]);
      p2_pc_r      <= 16'(p1_row_r[11:0]) * 16'(INNER);
      p2_pr_r      <= 28'(rank_sel_w) * 28'(full_rank_r[25:0]);
      p2_pi_r      <= 30'(p1_rank_r[11:0]) * 30'(inner_rank_r[17:0]);
    end
  end

  // ---------------- stage P3: ghost index sum ----------------
  logic signed [GW-1:0] hc_w, lyr_w, g_w, tot_w, pa_w, rank_part_w;

  always_comb begin
    hc_w = GW'(p2_col_r) + GW'(H);
    pa_w = GW'(p2_pa_r);
    if (p2_row_r < 0) begin
      lyr_w = pa_w + hc_w;
    end else if (p2_row_r < yn_s) begin
      if (p2_col_r < 0) begin
        lyr_w = base_part_r + GW'(p2_pc_r) + hc_w;
      end else begin
        lyr_w = base_part_r + GW'(p2_pc_r) + hc_w - GW'(cols_r);
      end
    end else begin
      lyr_w = base_top_r + GW'(p2_pb_r) + hc_w;
    end
    rank_part_w = GW'(p2_pr_r) + pa_w + hc_w;
    if (!is3d) begin
      g_w   = lyr_w;
      tot_w = total2d_r;
    end else begin
      tot_w = total3d_r;
      if (p2_rank_r < 0) begin
        g_w = rank_part_w;
      end else if (p2_rank_r < zn_s) begin
        g_w = base_int_r + GW'(p2_pi_r) + lyr_w;
      end else begin
        g_w = base_apex_r + rank_part_w;
      end
    end
  end

  logic                 p3_v_r, p3_bad_r, p3_owned_r, p3_outside_r;
  logic signed [GW-1:0] p3_g_r, p3_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_bad_r     <= p2_bad_r;
      p3_owned_r   <= p2_owned_r;
      p3_outside_r <= p2_outside_r;
      p3_g_r       <= g_w;
      p3_tot_r     <= tot_w;
    end
  end

  // ---------------- output register: range check and status ----------------
  logic [1:0]    status_nxt;
  logic [NW-1:0] index_nxt;
  logic [1:0]    out_status_r;
  logic [NW-1:0] out_index_r;

  always_comb begin
    index_nxt = '0;
    if (p3_bad_r) begin
      status_nxt = ST_OUTSIDE;
    end else if (p3_owned_r) begin
      status_nxt = ST_OWNED;
    end else if (p3_outside_r) begin
      status_nxt = ST_OUTSIDE;
    end else if ((p3_g_r < 0) || (p3_g_r >= p3_tot_r) ||
                 (p3_g_r > $signed(GW'(24'hFFFFFF)))) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = ST_GHOST;
      index_nxt  = p3_g_r[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= status_nxt;
      out_index_r  <= index_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_ghost_index = out_index_r;

  // ---------------- assertions ----------------
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_GHOST) |-> out_index_r == '0)
    else $error("ghost index nonzero on a non-ghost beat");

  a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> !(p2_owned_r && p2_outside_r))
    else $error("node classified both owned and outside");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_index_r) &&
    $stable(out_status_r))
    else $error("held output beat changed");

  a_stall_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p3_v_r) && $stable(p3_g_r))
    else $error("pipe moved during stall");

endmodule
`default_nettype wire
